@@ sv/dhtr_pkg.sv @@
// Shared types and constants for the single-wire humidity sensor receiver.
// Has no dependencies; every other file imports it.
package dhtr_pkg;

    localparam int FRAME_BYTES = 5;
    localparam int BYTE_IDX_W  = 3;
    localparam int BITS_LEFT_W = 4;
    localparam int TICK_W      = 16;
    localparam int WIDTH_W     = TICK_W + 2;

    localparam logic [BITS_LEFT_W-1:0] BITS_PER_BYTE = BITS_LEFT_W'(8);

    localparam logic [TICK_W-1:0] THRESHOLD_RESET = TICK_W'(800);
    localparam logic [TICK_W-1:0] WRAP_RESET      = TICK_W'(16000);

    // Configuration register indexes.
    localparam logic CFG_ONE_THRESHOLD = 1'b0;
    localparam logic CFG_TICK_WRAP     = 1'b1;

    typedef enum logic [2:0] {
        PH_INIT     = 3'd0,
        PH_IDLE     = 3'd1,
        PH_SENDING  = 3'd2,
        PH_WAIT_ACK = 3'd3,
        PH_ACK_IDLE = 3'd4,
        PH_BIT_SYNC = 3'd5,
        PH_BIT_END  = 3'd6
    } phase_t;

    typedef enum logic [1:0] {
        EDGE_NONE = 2'd0,
        EDGE_RISE = 2'd1,
        EDGE_FALL = 2'd2
    } edge_t;

    typedef enum logic [1:0] {
        ACT_START      = 2'd0,
        ACT_START_DONE = 2'd1,
        ACT_RISE       = 2'd2,
        ACT_FALL       = 2'd3
    } action_t;

    typedef logic [FRAME_BYTES-1:0][7:0] frame_t;

    typedef struct packed {
        action_t           action;
        logic [TICK_W-1:0] tick;
    } item_t;

    typedef struct packed {
        phase_t phase;
        logic   drive_low;
        logic   ready;
        frame_t bytes;
        logic   checksum_ok;
    } result_t;

endpackage

@@ sv/single_wire_humidity_sensor_receiver.sv @@
// Top level of the single-wire humidity sensor receiver: configuration registers,
// input register, frame core and result register. Depends on dhtr_pkg and the dhtr_* modules.
//
//   Channel   Handshake              Payload
//   --------  ---------------------  ------------------------------------------
//   input     in_valid / in_ready    action, tick_stamp
//   result    out_valid / out_ready  fsm_state, bus_drive_low, frame_complete,
//                                    five frame bytes, checksum_ok
//   config    cfg_valid / cfg_ready  cfg_index, cfg_data
//
// Each event is processed combinationally by the core between the input register and the
// result register, so one transfer per cycle is sustained while the result channel is not
// stalled; a result is presented from the result register once its event has passed the core.
// A stalled result register holds the core and fills the input register, after
// which in_ready drops. Reset clears the frame state and restores the
// configuration defaults; configuration writes are taken in every cycle.
module single_wire_humidity_sensor_receiver (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic [1:0]                  action,
    input  logic [dhtr_pkg::TICK_W-1:0] tick_stamp,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [2:0]                  fsm_state,
    output logic                        bus_drive_low,
    output logic                        frame_complete,
    output logic [7:0]                  humidity_int,
    output logic [7:0]                  humidity_frac,
    output logic [7:0]                  temperature_int,
    output logic [7:0]                  temperature_frac,
    output logic [7:0]                  check_byte,
    output logic                        checksum_ok,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic                        cfg_index,
    input  logic [dhtr_pkg::TICK_W-1:0] cfg_data
);
    import dhtr_pkg::*;

    logic [TICK_W-1:0] threshold_reg;
    logic [TICK_W-1:0] wrap_reg;

    item_t   item_in;
    item_t   item;
    logic    item_valid;
    logic    has_room;
    logic    step;
    result_t result_next;
    result_t result;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            threshold_reg <= THRESHOLD_RESET;
            wrap_reg      <= WRAP_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                CFG_ONE_THRESHOLD: threshold_reg <= cfg_data;
                CFG_TICK_WRAP:     wrap_reg      <= cfg_data;
                default:           threshold_reg <= threshold_reg;
            endcase
        end
    end

    assign item_in.action = action_t'(action);
    assign item_in.tick   = tick_stamp;

    // An event moves through the core only when the result register can take its result.
    assign step = item_valid && has_room;

    dhtr_in_stage u_in_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .item_in    (item_in),
        .take       (step),
        .item_valid (item_valid),
        .item_out   (item)
    );

    dhtr_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .step        (step),
        .item        (item),
        .threshold   (threshold_reg),
        .wrap        (wrap_reg),
        .result_next (result_next)
    );

    dhtr_out_stage u_out_stage (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (step),
        .result_in  (result_next),
        .has_room   (has_room),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .result_out (result)
    );

    assign fsm_state        = result.phase;
    assign bus_drive_low    = result.drive_low;
    assign frame_complete   = result.ready;
    assign humidity_int     = result.bytes[0];
    assign humidity_frac    = result.bytes[1];
    assign temperature_int  = result.bytes[2];
    assign temperature_frac = result.bytes[3];
    assign check_byte       = result.bytes[4];
    assign checksum_ok      = result.checksum_ok;

endmodule

@@ sv/dhtr_in_stage.sv @@
// Input register of the receiver: holds one accepted event until the core takes it.
// Depends on dhtr_pkg.
module dhtr_in_stage (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  dhtr_pkg::item_t item_in,
    input  logic           take,
    output logic           item_valid,
    output dhtr_pkg::item_t item_out
);
    import dhtr_pkg::*;

    logic  valid_reg;
    item_t item_reg;

    // The register frees up in the same cycle that the core takes its item.
    assign in_ready   = !valid_reg || take;
    assign item_valid = valid_reg;
    assign item_out   = item_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (in_ready)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            item_reg <= item_in;
        end
    end

endmodule

@@ sv/dhtr_core.sv @@
// Frame receiver state and its combinational update for one event, registered on step.
// Depends on dhtr_pkg.
module dhtr_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          step,
    input  dhtr_pkg::item_t               item,
    input  logic [dhtr_pkg::TICK_W-1:0]   threshold,
    input  logic [dhtr_pkg::TICK_W-1:0]   wrap,
    output dhtr_pkg::result_t             result_next
);
    import dhtr_pkg::*;

    phase_t                 phase_reg,     phase_next;
    edge_t                  armed_reg,     armed_next;
    logic [TICK_W-1:0]      start_reg,     start_next;
    frame_t                 bytes_reg,     bytes_next;
    logic [BITS_LEFT_W-1:0] bits_left_reg, bits_left_next;
    logic [BYTE_IDX_W-1:0]  byte_idx_reg,  byte_idx_next;
    logic                   ready_reg,     ready_next;
    logic                   drive_reg,     drive_next;

    logic                   edge_hit;
    logic [WIDTH_W-1:0]     wrap_add;
    logic [WIDTH_W-1:0]     pulse_width;
    logic                   bit_val;
    logic [BITS_LEFT_W-1:0] bits_dec;
    logic [BYTE_IDX_W-1:0]  byte_idx_inc;
    logic [7:0]             sum8;

    assign edge_hit = (item.action == ACT_RISE && armed_reg == EDGE_RISE) ||
                      (item.action == ACT_FALL && armed_reg == EDGE_FALL);

    // Pulse width with timer wrap correction, kept signed over two extra bits.
    assign wrap_add    = (item.tick <= start_reg) ? {2'b00, wrap} : '0;
    assign pulse_width = {2'b00, item.tick} + wrap_add - {2'b00, start_reg};
    assign bit_val     = $signed(pulse_width) > $signed({2'b00, threshold});

    assign bits_dec     = bits_left_reg - BITS_LEFT_W'(1);
    assign byte_idx_inc = (bits_dec == '0) ? byte_idx_reg + BYTE_IDX_W'(1) : byte_idx_reg;

    always_comb
    begin
        phase_next     = phase_reg;
        armed_next     = armed_reg;
        start_next     = start_reg;
        bytes_next     = bytes_reg;
        bits_left_next = bits_left_reg;
        byte_idx_next  = byte_idx_reg;
        ready_next     = ready_reg;
        drive_next     = drive_reg;

        unique case (item.action)
            ACT_START:
            begin
                phase_next     = PH_SENDING;
                bytes_next     = '0;
                bits_left_next = BITS_PER_BYTE;
                byte_idx_next  = '0;
                ready_next     = 1'b0;
                drive_next     = 1'b1;
            end
            ACT_START_DONE:
            begin
                drive_next = 1'b0;
                armed_next = EDGE_FALL;
                phase_next = PH_WAIT_ACK;
            end
            ACT_RISE, ACT_FALL:
            begin
                if (edge_hit)
                begin
                    unique case (phase_reg)
                        PH_WAIT_ACK:
                        begin
                            armed_next = EDGE_RISE;
                            phase_next = PH_ACK_IDLE;
                        end
                        PH_ACK_IDLE:
                        begin
                            phase_next = PH_BIT_SYNC;
                        end
                        PH_BIT_SYNC:
                        begin
                            start_next = item.tick;
                            armed_next = EDGE_FALL;
                            phase_next = PH_BIT_END;
                        end
                        PH_BIT_END:
                        begin
                            // Shift the bit into the byte being filled, MSB first.
                            for (int i = 0; i < FRAME_BYTES; i++)
                            begin
                                if (byte_idx_reg == BYTE_IDX_W'(i))
                                begin
                                    bytes_next[i] = {bytes_reg[i][6:0], bit_val};
                                end
                            end
                            bits_left_next = (bits_dec == '0) ? BITS_PER_BYTE : bits_dec;
                            byte_idx_next  = byte_idx_inc;
                            if (byte_idx_inc < BYTE_IDX_W'(FRAME_BYTES))
                            begin
                                armed_next = EDGE_RISE;
                                phase_next = PH_BIT_SYNC;
                            end
                            else
                            begin
                                armed_next = EDGE_NONE;
                                phase_next = PH_IDLE;
                                ready_next = 1'b1;
                            end
                        end
                        default:
                        begin
                            phase_next = PH_INIT;
                        end
                    endcase
                end
            end
            default:
            begin
                phase_next = phase_reg;
            end
        endcase
    end

    assign sum8 = bytes_next[0] + bytes_next[1] + bytes_next[2] + bytes_next[3];

    assign result_next.phase       = phase_next;
    assign result_next.drive_low   = drive_next;
    assign result_next.ready       = ready_next;
    assign result_next.bytes       = bytes_next;
    assign result_next.checksum_ok = (sum8 == bytes_next[4]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_INIT;
            armed_reg     <= EDGE_NONE;
            start_reg     <= '0;
            bytes_reg     <= '0;
            bits_left_reg <= BITS_PER_BYTE;
            byte_idx_reg  <= '0;
            ready_reg     <= 1'b0;
            drive_reg     <= 1'b0;
        end
        else if (step)
        begin
            phase_reg     <= phase_next;
            armed_reg     <= armed_next;
            start_reg     <= start_next;
            bytes_reg     <= bytes_next;
            bits_left_reg <= bits_left_next;
            byte_idx_reg  <= byte_idx_next;
            ready_reg     <= ready_next;
            drive_reg     <= drive_next;
        end
    end

endmodule

@@ sv/dhtr_out_stage.sv @@
// Result register of the receiver: holds one result until the consumer takes it.
// Depends on dhtr_pkg.
module dhtr_out_stage (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              load,
    input  dhtr_pkg::result_t result_in,
    output logic              has_room,
    output logic              out_valid,
    input  logic              out_ready,
    output dhtr_pkg::result_t result_out
);
    import dhtr_pkg::*;

    logic    valid_reg;
    result_t result_reg;

    assign has_room   = !valid_reg || out_ready;
    assign out_valid  = valid_reg;
    assign result_out = result_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (has_room)
        begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            result_reg <= result_in;
        end
    end

endmodule

@@ dv/testbench.sv @@
// Self-checking testbench for the single-wire humidity sensor receiver.
// Depends on dhtr_pkg and the receiver RTL; it predicts every result in step with
// the accepted events and compares each transfer on the result channel.
module testbench;
    import dhtr_pkg::*;

    localparam int STALL_LIMIT = 3000;
    localparam int RANDOM_ITEMS = 1040;
    localparam int SETTINGS_N = 6;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;
    logic              in_valid = 1'b0;
    logic              in_ready;
    logic [1:0]        action = 2'd0;
    logic [TICK_W-1:0] tick_stamp = '0;
    logic              out_valid;
    logic              out_ready = 1'b0;
    logic [2:0]        fsm_state;
    logic              bus_drive_low;
    logic              frame_complete;
    logic [7:0]        humidity_int;
    logic [7:0]        humidity_frac;
    logic [7:0]        temperature_int;
    logic [7:0]        temperature_frac;
    logic [7:0]        check_byte;
    logic              checksum_ok;
    logic              cfg_valid = 1'b0;
    logic              cfg_ready;
    logic              cfg_index = CFG_ONE_THRESHOLD;
    logic [TICK_W-1:0] cfg_data = '0;

    single_wire_humidity_sensor_receiver dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready),
        .action(action), .tick_stamp(tick_stamp),
        .out_valid(out_valid), .out_ready(out_ready),
        .fsm_state(fsm_state), .bus_drive_low(bus_drive_low),
        .frame_complete(frame_complete),
        .humidity_int(humidity_int), .humidity_frac(humidity_frac),
        .temperature_int(temperature_int), .temperature_frac(temperature_frac),
        .check_byte(check_byte), .checksum_ok(checksum_ok),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #6 clk = ~clk;

    // Receiver state as predicted from the accepted events.
    logic [TICK_W-1:0]      one_thr = THRESHOLD_RESET;
    logic [TICK_W-1:0]      wrap_ticks = WRAP_RESET;
    phase_t                 rx_phase = PH_INIT;
    edge_t                  armed_pol = EDGE_NONE;
    logic [TICK_W-1:0]      rise_tick = '0;
    frame_t                 rx_bytes = '0;
    logic [BITS_LEFT_W-1:0] bits_to_go = BITS_PER_BYTE;
    logic [BYTE_IDX_W-1:0]  byte_pos = '0;
    logic                   frame_done = 1'b0;
    logic                   pull_low = 1'b0;

    item_t   event_q[$];
    result_t frame_status_q[$];
    int      mismatches = 0;
    int      events_queued = 0;
    int      quiet_cycles = 0;
    int      send_gap = 0;
    int      hold_left = 0;
    int      calm_left = 0;
    bit      in_fire = 1'b0;
    logic [TICK_W-1:0] tick_now = '0;

    function automatic result_t sensor_step(item_t ev);
        int         pulse_w;
        logic [7:0] sum;
        result_t    r;
        case (ev.action)
            ACT_START:
            begin
                rx_phase = PH_SENDING;
                rx_bytes = '0;
                bits_to_go = BITS_PER_BYTE;
                byte_pos = '0;
                frame_done = 1'b0;
                pull_low = 1'b1;
            end
            ACT_START_DONE:
            begin
                pull_low = 1'b0;
                armed_pol = EDGE_FALL;
                rx_phase = PH_WAIT_ACK;
            end
            default:
            begin
                if ((ev.action == ACT_RISE && armed_pol == EDGE_RISE) ||
                    (ev.action == ACT_FALL && armed_pol == EDGE_FALL))
                begin
                    case (rx_phase)
                        PH_WAIT_ACK:
                        begin
                            armed_pol = EDGE_RISE;
                            rx_phase = PH_ACK_IDLE;
                        end
                        PH_ACK_IDLE: rx_phase = PH_BIT_SYNC;
                        PH_BIT_SYNC:
                        begin
                            rise_tick = ev.tick;
                            armed_pol = EDGE_FALL;
                            rx_phase = PH_BIT_END;
                        end
                        PH_BIT_END:
                        begin
                            // The timer period is added when the end stamp does not
                            // exceed the start stamp.
                            pulse_w = int'(ev.tick) - int'(rise_tick);
                            if (ev.tick <= rise_tick)
                                pulse_w += int'(wrap_ticks);
                            if (byte_pos < FRAME_BYTES)
                                rx_bytes[byte_pos] = {rx_bytes[byte_pos][6:0],
                                                      pulse_w > int'(one_thr)};
                            bits_to_go = bits_to_go - 1'b1;
                            if (bits_to_go == 0)
                            begin
                                bits_to_go = BITS_PER_BYTE;
                                byte_pos = byte_pos + 1'b1;
                            end
                            if (byte_pos < FRAME_BYTES)
                            begin
                                armed_pol = EDGE_RISE;
                                rx_phase = PH_BIT_SYNC;
                            end
                            else
                            begin
                                rx_phase = PH_IDLE;
                                armed_pol = EDGE_NONE;
                                frame_done = 1'b1;
                            end
                        end
                        default: rx_phase = PH_INIT;
                    endcase
                end
            end
        endcase
        sum = rx_bytes[0] + rx_bytes[1] + rx_bytes[2] + rx_bytes[3];
        r.phase = rx_phase;
        r.drive_low = pull_low;
        r.ready = frame_done;
        r.bytes = rx_bytes;
        r.checksum_ok = (sum == rx_bytes[4]);
        return r;
    endfunction

    function automatic int pick_gap();
        int r;
        if (calm_left > 0)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void queue_event(action_t a, logic [TICK_W-1:0] t);
        item_t it;
        it.action = a;
        it.tick = t;
        event_q.push_back(it);
        events_queued++;
    endfunction

    // High-pulse width of one data bit, mostly at or around the threshold, sometimes zero or any 16-bit value.
    function automatic int pick_width();
        case ($urandom_range(0, 9))
            0: return int'(one_thr);
            1: return int'(one_thr) + 1;
            2: return int'(one_thr) - 1;
            3: return 0;
            4: return $urandom_range(0, 65535);
            default: return $urandom_range(0, 2 * int'(one_thr) + 16);
        endcase
    endfunction

    // Queues a well-formed frame, cut after the first keep events.
    task automatic add_frame(input bit with_start, input int keep);
        item_t seq[$];
        item_t it;
        int    w;
        if (with_start)
        begin
            it.action = ACT_START;
            it.tick = tick_now;
            seq.push_back(it);
        end
        it.action = ACT_START_DONE;
        it.tick = tick_now;
        seq.push_back(it);
        it.action = ACT_FALL;
        it.tick = tick_now + 16'd30;
        seq.push_back(it);
        it.action = ACT_RISE;
        it.tick = tick_now + 16'd110;
        seq.push_back(it);
        tick_now = tick_now + 16'd190;
        repeat (41)
        begin
            it.action = ACT_RISE;
            it.tick = tick_now;
            seq.push_back(it);
            w = pick_width();
            tick_now = tick_now + 16'(w);
            it.action = ACT_FALL;
            it.tick = tick_now;
            seq.push_back(it);
            tick_now = tick_now + 16'($urandom_range(20, 120));
        end
        // Forty bits complete the frame and disarm both edges, so the last rise
        // above is ignored; its fall is dropped.
        void'(seq.pop_back());
        foreach (seq[i])
            if (i < keep)
                queue_event(seq[i].action, seq[i].tick);
    endtask

    task automatic report_mismatch(input string field, input int got, input int want);
        if (mismatches < 60)
            $display("ERROR at %0t: %s is %0h, predicted %0h", $time, field, got, want);
        mismatches++;
    endtask

    task automatic wait_drained(input int settle);
        while (event_q.size() > 0 || in_valid || frame_status_q.size() > 0)
            @(posedge clk);
        repeat (settle) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [TICK_W-1:0] val);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        do
            @(posedge clk);
        while (!(cfg_valid && cfg_ready));
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Input driver: a new event is presented only once the previous one transferred.
    always @(negedge clk)
    begin
        item_t nxt;
        if (rst_n && (!in_valid || in_fire))
        begin
            if (send_gap > 0)
            begin
                send_gap--;
                in_valid <= 1'b0;
            end
            else if (event_q.size() > 0)
            begin
                nxt = event_q.pop_front();
                action <= nxt.action;
                tick_stamp <= nxt.tick;
                in_valid <= 1'b1;
                send_gap = pick_gap();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Result-side back-pressure, with occasional stretches of none at all.
    always @(negedge clk)
    begin
        if (calm_left > 0)
            calm_left--;
        else if ($urandom_range(0, 299) == 0)
            calm_left = $urandom_range(40, 160);
        if (hold_left > 0)
        begin
            hold_left--;
            out_ready <= 1'b0;
        end
        else
        begin
            out_ready <= 1'b1;
            hold_left = pick_gap();
        end
    end

    always @(posedge clk)
    begin
        result_t want;
        in_fire = in_valid && in_ready;
        if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_ONE_THRESHOLD)
                one_thr = cfg_data;
            else
                wrap_ticks = cfg_data;
        end
        if (in_fire)
            frame_status_q.push_back(sensor_step(item_t'{action_t'(action), tick_stamp}));
        if (out_valid && out_ready)
        begin
            if (frame_status_q.size() == 0)
                report_mismatch("result with nothing outstanding", fsm_state, 0);
            else
            begin
                want = frame_status_q.pop_front();
                if (fsm_state != want.phase)
                    report_mismatch("fsm_state", fsm_state, want.phase);
                if (bus_drive_low != want.drive_low)
                    report_mismatch("bus_drive_low", bus_drive_low, want.drive_low);
                if (frame_complete != want.ready)
                    report_mismatch("frame_complete", frame_complete, want.ready);
                if (humidity_int != want.bytes[0])
                    report_mismatch("humidity_int", humidity_int, want.bytes[0]);
                if (humidity_frac != want.bytes[1])
                    report_mismatch("humidity_frac", humidity_frac, want.bytes[1]);
                if (temperature_int != want.bytes[2])
                    report_mismatch("temperature_int", temperature_int, want.bytes[2]);
                if (temperature_frac != want.bytes[3])
                    report_mismatch("temperature_frac", temperature_frac, want.bytes[3]);
                if (check_byte != want.bytes[4])
                    report_mismatch("check_byte", check_byte, want.bytes[4]);
                if (checksum_ok != want.checksum_ok)
                    report_mismatch("checksum_ok", checksum_ok, want.checksum_ok);
            end
        end
    end

    always @(posedge clk)
    begin
        if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("single_wire_humidity_sensor_receiver: mismatch");
            $finish;
        end
    end

    initial
    begin
        logic [TICK_W-1:0] thr_set [SETTINGS_N];
        logic [TICK_W-1:0] wrap_set [SETTINGS_N];
        int phase_goal;
        int pick;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed events under the reset settings.
        queue_event(ACT_RISE, 16'h0000);       // nothing armed yet
        queue_event(ACT_FALL, 16'hFFFF);
        queue_event(ACT_START_DONE, 16'd0);    // without a start first
        queue_event(ACT_FALL, 16'd5);
        queue_event(ACT_START, 16'd7);         // rising edges stay armed
        queue_event(ACT_RISE, 16'd9);          // armed edge while sending start
        queue_event(ACT_RISE, 16'd11);         // armed edge in init
        queue_event(ACT_FALL, 16'd12);
        queue_event(ACT_START, 16'd0);
        queue_event(ACT_START_DONE, 16'd0);
        queue_event(ACT_FALL, 16'd20);
        queue_event(ACT_RISE, 16'd30);
        queue_event(ACT_RISE, 16'd40);
        queue_event(ACT_FALL, 16'd840);        // exactly the threshold is a zero
        queue_event(ACT_RISE, 16'd1000);
        queue_event(ACT_FALL, 16'd1801);       // one tick above is a one
        queue_event(ACT_RISE, 16'hFFFF);
        queue_event(ACT_FALL, 16'h0000);       // wrapped stamp, width negative
        queue_event(ACT_RISE, 16'd500);
        queue_event(ACT_FALL, 16'd500);        // equal stamps take the full period
        queue_event(ACT_RISE, 16'd100);
        queue_event(ACT_FALL, 16'd50);
        queue_event(ACT_START_DONE, 16'd3);    // restart of the ack mid-frame
        queue_event(ACT_START, 16'hFFFF);
        wait_drained(4);

        thr_set = '{THRESHOLD_RESET, 16'd0, 16'hFFFF, 16'($urandom_range(0, 65535)),
                    THRESHOLD_RESET, 16'($urandom_range(0, 2000))};
        wrap_set = '{WRAP_RESET, 16'd1, 16'hFFFF, 16'($urandom_range(1, 65535)),
                     WRAP_RESET, 16'($urandom_range(1, 65535))};

        for (int s = 0; s < SETTINGS_N; s++)
        begin
            // The first pass keeps the reset settings; every register is written later.
            if (s > 0)
            begin
                write_reg(CFG_ONE_THRESHOLD, thr_set[s]);
                write_reg(CFG_TICK_WRAP, wrap_set[s]);
            end
            phase_goal = events_queued + RANDOM_ITEMS / SETTINGS_N;
            while (events_queued < phase_goal)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 65)
                    add_frame(1'b1, 1000);
                else if (pick < 75)
                    add_frame(1'b0, 1000);
                else if (pick < 88)
                    add_frame(1'b1, $urandom_range(1, 84));
                else
                    repeat ($urandom_range(1, 6))
                        queue_event(action_t'($urandom_range(0, 3)),
                                    16'($urandom_range(0, 65535)));
            end
            // The sender holds off here until every predicted result has arrived.
            wait_drained(4);
        end

        wait_drained(6);
        if (mismatches == 0)
            $display("single_wire_humidity_sensor_receiver: match");
        else
            $display("single_wire_humidity_sensor_receiver: mismatch");
        $finish;
    end
endmodule

@@ sim.f @@
sv/dhtr_pkg.sv
sv/dhtr_in_stage.sv
sv/dhtr_core.sv
sv/dhtr_out_stage.sv
sv/single_wire_humidity_sensor_receiver.sv
dv/testbench.sv
